// File: rtl/core/fixed_block_slot_allocator_top_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIXED_BLOCK_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_BLOCK_SLOT_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FBSA_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("fbsa: same-cycle check failed");
`define FBSA_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("fbsa: next-cycle check failed");
`else
`define FBSA_ASSERT_IMP(label, clk, rst_n, pre, post)
`define FBSA_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

// File: rtl/core/fbsa_pkg.sv
// Types and constants shared by the fixed block slot allocator.
package fbsa_pkg;

	localparam int ADDR_W    = 32;
	localparam int SIZE_W    = 16;
	localparam int COUNT_W   = 6;
	localparam int FUNC_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

	localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = '0;
	localparam logic [SIZE_W-1:0]  RST_BLOCK_SIZE   = 16'd1;
	localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT  = 6'd32;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] block_address;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   granted_address;
		logic [COUNT_W-1:0]  used_count;
		logic [COUNT_W-1:0]  free_count;
		logic [COUNT_W-1:0]  high_watermark;
	} rsp_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
	} dp_status_t;

endpackage

// File: rtl/core/fbsa_ctrl.sv
// Sequencer for the allocator: accepts an item, walks the slots, hands off the result.
module fbsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output fbsa_pkg::dp_cmd_t    cmd,
	input  fbsa_pkg::dp_status_t stat
);
	import fbsa_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;
	logic   rsp_free;

	// The output register can take a new item when empty or being drained.
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_done) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (rsp_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.start = req_valid;
			end
			S_SCAN: begin
				cmd.step = !stat.scan_done;
			end
			S_FINISH: begin
				cmd.load = rsp_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// File: rtl/core/fbsa_dp.sv
// Datapath: configuration, slot map, address walker, counters and result register.
module fbsa_dp #(
	parameter int MAX_BLOCKS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fbsa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fbsa_pkg::ADDR_W-1:0]          cfg_data,
	input  fbsa_pkg::req_item_t                  req,
	input  fbsa_pkg::dp_cmd_t                    cmd,
	output fbsa_pkg::dp_status_t                 stat,
	output fbsa_pkg::rsp_item_t                  rsp
);
	import fbsa_pkg::*;

	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int SLOT_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	logic [ADDR_W-1:0]     base_q;
	logic [SIZE_W-1:0]     size_q;
	logic [COUNT_W-1:0]    count_q;
	logic [MAX_BLOCKS-1:0] slot_used_q;
	logic [COUNT_W-1:0]    peak_q;

	logic [FUNC_W-1:0]     func_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ADDR_W-1:0]     acc_q;
	logic [CNT_W-1:0]      used_q;
	logic                  found_q;
	logic [ADDR_W-1:0]     grant_q;
	rsp_item_t             rsp_q;

	logic [CNT_W-1:0]      n_act;
	logic [SLOT_W-1:0]     idx;
	logic                  cur_bit;
	logic                  is_alloc;
	logic                  is_rel;
	logic                  hit;
	logic                  new_bit;
	logic [COUNT_W-1:0]    used6;
	logic [COUNT_W-1:0]    free6;
	logic [COUNT_W-1:0]    peak_nxt;
	logic [STATUS_W-1:0]   status_nxt;

	// Active slots: block_count saturated at the pool depth.
	assign n_act = (32'(count_q) >= MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(count_q);

	assign idx      = cnt_q[SLOT_W-1:0];
	assign cur_bit  = slot_used_q[idx];
	assign is_alloc = (func_q == FUNC_ALLOC);
	assign is_rel   = (func_q == FUNC_RELEASE);

	// Only the first free slot (allocate) or first address match (release) is taken.
	assign hit     = !found_q && ((is_alloc && !cur_bit) || (is_rel && (acc_q == addr_q)));
	assign new_bit = hit ? is_alloc : cur_bit;

	assign stat.scan_done = (cnt_q == n_act);

	// The active count never exceeds 63, so the narrowing below loses nothing.
	assign used6    = COUNT_W'(used_q);
	assign free6    = COUNT_W'(n_act - used_q);
	assign peak_nxt = (is_alloc && found_q && (used6 > peak_q)) ? used6 : peak_q;

	always_comb begin
		case (func_q)
			FUNC_ALLOC:   status_nxt = found_q ? ST_OK : ST_FULL;
			FUNC_RELEASE: status_nxt = found_q ? ST_OK : ST_NOT_FOUND;
			default:      status_nxt = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= RST_BASE_ADDRESS;
			size_q      <= RST_BLOCK_SIZE;
			count_q     <= RST_BLOCK_COUNT;
			slot_used_q <= '0;
			peak_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASE_ADDRESS: base_q  <= cfg_data;
					CFG_BLOCK_SIZE:   size_q  <= cfg_data[SIZE_W-1:0];
					CFG_BLOCK_COUNT:  count_q <= cfg_data[COUNT_W-1:0];
					default:          ;
				endcase
			end
			if (cmd.start && (req.func == FUNC_CLEAR)) begin
				slot_used_q <= '0;
				peak_q      <= '0;
			end
			if (cmd.step) begin
				slot_used_q[idx] <= new_bit;
			end
			if (cmd.load) begin
				peak_q <= peak_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q  <= req.func;
			addr_q  <= req.block_address;
			cnt_q   <= '0;
			acc_q   <= base_q;
			used_q  <= '0;
			found_q <= 1'b0;
			grant_q <= '0;
		end
		if (cmd.step) begin
			cnt_q  <= cnt_q + CNT_W'(1);
			acc_q  <= acc_q + ADDR_W'(size_q);
			used_q <= used_q + CNT_W'(new_bit);
			if (hit) begin
				found_q <= 1'b1;
				if (is_alloc) begin
					grant_q <= acc_q;
				end
			end
		end
		if (cmd.load) begin
			rsp_q.status          <= status_nxt;
			rsp_q.granted_address <= grant_q;
			rsp_q.used_count      <= used6;
			rsp_q.free_count      <= free6;
			rsp_q.high_watermark  <= peak_nxt;
		end
	end

	assign rsp = rsp_q;

endmodule

// File: rtl/core/fixed_block_slot_allocator_top.sv
// Fixed block slot allocator: top level with sequencer, datapath and checks.
//
// Requests enter on req (func, block_address) with req_valid/req_stall and
// results leave on rsp with rsp_valid/rsp_stall; each request yields one result.
// Allocate grants the lowest free slot, release clears the lowest slot whose
// address matches, clear empties the pool and its high watermark.
// Configuration registers (0 base address, 1 block size, 2 block count) are
// written over cfg_valid/cfg_index/cfg_data; cfg_ready is always high and
// writes are expected only while the block is idle.
// The slot walker visits one slot per cycle over the n active slots
// (n = min(block_count, MAX_BLOCKS)); req_stall stays high from the accepting
// edge until the result is loaded into the result register.
// The result register lets the next request be walked while a result is
// still stalled; that request then waits in its last step until the
// register drains. Reset empties every slot, clears the watermark and loads
// the register defaults (base 0, size 1, count 32).
`include "fixed_block_slot_allocator_top_defines.svh"

module fixed_block_slot_allocator_top #(
	parameter int MAX_BLOCKS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  fbsa_pkg::req_item_t             req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output fbsa_pkg::rsp_item_t             rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fbsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbsa_pkg::ADDR_W-1:0]     cfg_data
);
	import fbsa_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t stat;

	assign cfg_ready = 1'b1;

	fbsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	fbsa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

	// A request is walked alone: the block is busy right after taking one.
	`FBSA_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall)
	// A full pool has no free slot and grants nothing.
	`FBSA_ASSERT_IMP(a_full_consistent, clk, arst_n, rsp_valid && (rsp.status == ST_FULL), (rsp.free_count == '0) && (rsp.granted_address == '0))
	// A drained result without a new load leaves the output empty.
	`FBSA_ASSERT_NXT(a_rsp_drains, clk, arst_n, rsp_valid && !rsp_stall && !cmd.load, !rsp_valid)

endmodule
